// ----- rtl/core/first_fit_heap_allocator_core_macros.svh -----
// assertion macros shared by the allocator rtl
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define FFA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define FFA_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/ffha_pkg.sv -----
// shared types and codes for the first-fit heap allocator
`timescale 1ns / 1ps
package ffha_pkg;
  localparam logic       ACT_ALLOC  = 1'b0;
  localparam logic       ACT_FREE   = 1'b1;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;
  localparam int unsigned FIELD_BITS = 20;
  localparam int unsigned STATUS_BITS = 2;

  // per-cell control of the block chain
  typedef struct packed {
    logic shl;   // each cell takes the content of its right neighbor
    logic shr;   // each cell takes the content of its left neighbor
    logic rot;   // walk: each cell takes the right neighbor, the last cell gets cell 0
  } ffha_ctl_t;
endpackage

// ----- rtl/core/ffha_if.sv -----
// valid/ready channel with generic payload
`timescale 1ns / 1ps
interface ffha_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/ffha_cell.sv -----
// one table entry of the block chain
`timescale 1ns / 1ps
module ffha_cell
  import ffha_pkg::*;
#(
  parameter int unsigned AW = 20
) (
  input  logic          clk,
  input  logic          ld,
  input  logic [AW-1:0] ld_start,
  input  logic [AW-1:0] ld_size,
  input  logic          ld_free,
  input  logic          ld_used,
  input  ffha_ctl_t     ctl,
  input  logic [AW-1:0] l_start,
  input  logic [AW-1:0] l_size,
  input  logic          l_free,
  input  logic          l_used,
  input  logic [AW-1:0] r_start,
  input  logic [AW-1:0] r_size,
  input  logic          r_free,
  input  logic          r_used,
  output logic [AW-1:0] start_o,
  output logic [AW-1:0] size_o,
  output logic          free_o,
  output logic          used_o
);
  logic [AW-1:0] start_r, size_r;
  logic          free_r, used_r;

  always_ff @(posedge clk) begin
    priority if (ld) begin
      start_r <= ld_start; size_r <= ld_size; free_r <= ld_free; used_r <= ld_used;
    end else if (ctl.shl || ctl.rot) begin
      start_r <= r_start; size_r <= r_size; free_r <= r_free; used_r <= r_used;
    end else if (ctl.shr) begin
      start_r <= l_start; size_r <= l_size; free_r <= l_free; used_r <= l_used;
    end else begin
      start_r <= start_r; size_r <= size_r; free_r <= free_r; used_r <= used_r;
    end
  end

  assign start_o = start_r;
  assign size_o  = size_r;
  assign free_o  = free_r;
  assign used_o  = used_r;
endmodule

// ----- rtl/core/first_fit_heap_allocator_core.sv -----
// first-fit heap allocator top level: chain of table cells plus sequencer
// flow: an item is scanned entry by entry until a hit, edited at the hit position, realigned
//   by rotating the rest back, then posted at its done step; a hit at entry 0 skips realignment
// one item at a time: the input opens again only after the item has posted its result;
//   a result held by the receiver stalls only the following item at its done step
// reset and heap_size writes reload the table in the init state, then the input opens
`timescale 1ns / 1ps
`include "first_fit_heap_allocator_core_macros.svh"
module first_fit_heap_allocator_core
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned ADDR_BITS    = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [FIELD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [FIELD_BITS-1:0] in_request_size,
  input  logic [FIELD_BITS-1:0] in_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FIELD_BITS-1:0] out_address_out,
  output logic [STATUS_BITS-1:0] out_status
);
  localparam int unsigned N  = MAX_BLOCKS;
  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  // sequencer states
  localparam logic [2:0] S_INIT = 3'd0;  // clear sweep
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;  // rotate and test cell 0
  localparam logic [2:0] S_EDIT = 3'd3;  // apply the edit at the hit position
  localparam logic [2:0] S_ALGN = 3'd4;  // rotate the rest back into place
  localparam logic [2:0] S_DONE = 3'd5;

  // The table is edited in "aligned" form: entry k in cell k.
  // Scan: rotate left one step per cycle, count rotations r. When the hit
  // entry sits in cell 0 we stop. Edits use shifts of the suffix region:
  // the prefix entries already rotated out lie at the tail of the chain
  // (cells N-r..N-1), so a split/remove is done by shifting only cells
  // [0 .. N-r-1] and then the rotation is completed.

  logic [2:0]     state_r, state_nxt;
  logic [AW-1:0]  heap_r;
  logic [IW-1:0]  cnt_r;          // rotations done
  logic [CW-1:0]  bcnt_r;         // block count
  logic [CW-1:0]  ipos_r;         // hit index
  logic           act_r;
  logic [AW-1:0]  req_r, adr_r;
  logic           hit_r;
  logic [1:0]     phase_r;        // edit sub-step
  logic [AW-1:0]  ores_r;
  logic [1:0]     ost_r;
  logic           ovld_r;
  logic [AW-1:0]  rsp_addr_r;     // posted result, held until its transfer
  logic [1:0]     rsp_stat_r;

  logic [AW-1:0] st [N];
  logic [AW-1:0] sz [N];
  logic          fr [N];
  logic          us [N];

  // per-cell controls; masks select which cells move
  logic [N-1:0] m_shl, m_shr, m_rot, m_ld;
  logic [AW-1:0] ld_st [N];
  logic [AW-1:0] ld_sz [N];
  logic          ld_fr [N];
  logic          ld_us [N];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      ffha_ctl_t c;
      assign c = '{shl: m_shl[g], shr: m_shr[g], rot: m_rot[g]};
      ffha_cell #(.AW(AW)) u_cell (
        .clk(clk), .ld(m_ld[g]), .ld_start(ld_st[g]), .ld_size(ld_sz[g]),
        .ld_free(ld_fr[g]), .ld_used(ld_us[g]), .ctl(c),
        .l_start(st[(g+N-1)%N]), .l_size(sz[(g+N-1)%N]),
        .l_free(fr[(g+N-1)%N]), .l_used(us[(g+N-1)%N]),
        .r_start(st[(g+1)%N]), .r_size(sz[(g+1)%N]),
        .r_free(fr[(g+1)%N]), .r_used(us[(g+1)%N]),
        .start_o(st[g]), .size_o(sz[g]), .free_o(fr[g]), .used_o(us[g]));
    end
  endgenerate

  // edit happens with hit entry in cell 0; live suffix is cells 0..L-1, L = bcnt - ipos
  logic [CW-1:0] live_len;
  assign live_len = bcnt_r - ipos_r;

  logic [AW:0] need;
  assign need = {1'b0, req_r} + {1'b0, HDR};
  logic fit0, match0, do_split;
  assign fit0   = us[0] && fr[0] && (sz[0] >= req_r);
  assign match0 = us[0] && (st[0] == adr_r);
  assign do_split = ({1'b0, sz[0]} >= need) && (bcnt_r < CW'(N));

  // in free: phase 0 merges next, phase 1 merges previous (prev lies at cell N-1)
  logic prev_ok;
  assign prev_ok = (ipos_r != '0) && fr[N-1];

  always_comb begin
    m_shl = '0; m_shr = '0; m_rot = '0; m_ld = '0;
    for (int k = 0; k < N; k++) begin
      ld_st[k] = st[k]; ld_sz[k] = sz[k]; ld_fr[k] = fr[k]; ld_us[k] = us[k];
    end
    unique case (state_r)
      S_INIT: begin
        m_ld = '1;
        for (int k = 0; k < N; k++) begin
          ld_st[k] = '0; ld_sz[k] = '0; ld_fr[k] = 1'b0; ld_us[k] = 1'b0;
        end
        ld_st[0] = HDR; ld_sz[0] = heap_r; ld_fr[0] = 1'b1; ld_us[0] = 1'b1;
      end
      S_SCAN: begin
        if (!(act_r == ACT_ALLOC ? fit0 : match0) && us[0]) m_rot = '1;
      end
      S_EDIT: begin
        if (act_r == ACT_ALLOC) begin
          if (phase_r == 2'd0 && do_split) begin
            // open slot at cell 1: shift cells 1..live_len right
            for (int k = 1; k < N; k++)
              if (CW'(k) <= live_len) m_shr[k] = 1'b1;
          end else if (phase_r == 2'd1 && hit_r) begin
            m_ld[1] = 1'b1;
            ld_st[1] = st[0] + need[AW-1:0];
            ld_sz[1] = sz[0] - need[AW-1:0];
            ld_fr[1] = 1'b1; ld_us[1] = 1'b1;
            m_ld[0] = 1'b1; ld_sz[0] = req_r; ld_fr[0] = 1'b0;
          end else if (phase_r == 2'd1) begin
            m_ld[0] = 1'b1; ld_fr[0] = 1'b0;
          end
        end else begin
          if (phase_r == 2'd0) begin
            m_ld[0] = 1'b1; ld_fr[0] = 1'b1;
            if (live_len > CW'(1) && fr[1] && us[1]) begin
              ld_sz[0] = sz[0] + HDR + sz[1];
              for (int k = 1; k < N; k++)
                if (CW'(k) < live_len) m_shl[k] = 1'b1;
              m_ld[live_len[IW-1:0] - IW'(1)] = 1'b1;
              ld_st[live_len[IW-1:0] - IW'(1)] = '0;
              ld_sz[live_len[IW-1:0] - IW'(1)] = '0;
              ld_fr[live_len[IW-1:0] - IW'(1)] = 1'b0;
              ld_us[live_len[IW-1:0] - IW'(1)] = 1'b0;
            end
          end else if (phase_r == 2'd1 && prev_ok) begin
            // fold cell 0 into cell N-1, then close the gap at the suffix
            m_ld[N-1] = 1'b1; ld_sz[N-1] = sz[N-1] + HDR + sz[0];
            for (int k = 0; k < N-1; k++)
              if (CW'(k) < live_len - CW'(1)) m_shl[k] = 1'b1;
            m_ld[live_len[IW-1:0] - IW'(1)] = 1'b1;
            ld_st[live_len[IW-1:0] - IW'(1)] = '0;
            ld_sz[live_len[IW-1:0] - IW'(1)] = '0;
            ld_fr[live_len[IW-1:0] - IW'(1)] = 1'b0;
            ld_us[live_len[IW-1:0] - IW'(1)] = 1'b0;
          end
        end
      end
      S_ALGN: m_rot = '1;
      default: ;
    endcase
  end

  logic in_fire, out_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  // the result register parts the sides, so a held result does not block the input
  assign in_ready = (state_r == S_IDLE) && !cfg_we;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: if (in_fire) state_nxt = S_SCAN;
      S_SCAN: begin
        if (!us[0]) state_nxt = S_ALGN;
        else if (act_r == ACT_ALLOC ? fit0 : match0) state_nxt = S_EDIT;
      end
      S_EDIT: if (phase_r == 2'd1) state_nxt = S_ALGN;
      // one rotation per cycle, cnt_r..1
      S_ALGN: if (cnt_r == IW'(1)) state_nxt = S_DONE;
      // wait here while the previous result is still held
      S_DONE: if (!ovld_r || out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  // rotations needed to return to aligned: N - r, counted in cnt_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; heap_r <= AW'(65536); bcnt_r <= CW'(1);
      ovld_r <= 1'b0; cnt_r <= '0; phase_r <= '0; hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) ovld_r <= 1'b0;
      if (cfg_we) begin
        heap_r <= cfg_wdata[AW-1:0]; state_r <= S_INIT;
      end
      unique case (state_r)
        S_INIT: bcnt_r <= CW'(1);
        S_IDLE: if (in_fire) begin
          act_r <= in_action; req_r <= in_request_size[AW-1:0];
          adr_r <= in_address[AW-1:0]; cnt_r <= '0; ipos_r <= '0;
          phase_r <= '0; hit_r <= 1'b0; ost_r <= ST_OK; ores_r <= '0;
        end
        S_SCAN: begin
          if (!us[0]) begin
            ost_r <= (act_r == ACT_ALLOC) ? ST_NOFIT : ST_NOTFND;
            cnt_r <= IW'(N - 1) - cnt_r + IW'(1);
            if (cnt_r == '0) cnt_r <= '0;
          end else if (act_r == ACT_ALLOC ? fit0 : match0) begin
            ipos_r <= CW'(cnt_r);
            if (act_r == ACT_ALLOC) begin
              ores_r <= st[0]; hit_r <= do_split;
            end
          end else begin
            cnt_r <= cnt_r + IW'(1);
            ipos_r <= ipos_r + CW'(1);
            if (ipos_r + CW'(1) == CW'(N)) begin
              ost_r <= (act_r == ACT_ALLOC) ? ST_NOFIT : ST_NOTFND;
              state_r <= S_DONE;
            end
          end
        end
        S_EDIT: begin
          phase_r <= phase_r + 2'd1;
          if (phase_r == 2'd0) begin
            if (act_r == ACT_ALLOC && do_split) bcnt_r <= bcnt_r + CW'(1);
            if (act_r == ACT_FREE && live_len > CW'(1) && fr[1] && us[1]) begin
              bcnt_r <= bcnt_r - CW'(1);
            end
          end else begin
            if (act_r == ACT_FREE && prev_ok) bcnt_r <= bcnt_r - CW'(1);
            cnt_r <= (cnt_r == '0) ? '0 : IW'(N) - cnt_r;
            if (cnt_r == '0) state_r <= S_DONE;
          end
        end
        S_ALGN: cnt_r <= cnt_r - IW'(1);
        S_DONE: begin
          // post the result once the result register is free
          if (!ovld_r || out_fire) begin
            ovld_r <= 1'b1;
            rsp_addr_r <= ores_r;
            rsp_stat_r <= ost_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = ovld_r;
  assign out_address_out = FIELD_BITS'(rsp_addr_r);
  assign out_status      = rsp_stat_r;

  `FFA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `FFA_ASSERT_NXT(a_take_scan, clk, rst_n, in_fire && !cfg_we, state_r == S_SCAN)
  `FFA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, bcnt_r <= CW'(N) && bcnt_r != '0)
endmodule

// ----- verif/tb_first_fit_heap_allocator_core.sv -----
// self-checking testbench for the first-fit heap allocator core
`timescale 1ns / 1ps

// tracks the block table, predicts each response and checks it against the core
class alloc_scoreboard;
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HDR         = 32;
  localparam logic [63:0] FIELD_MASK  = 64'hFFFFF;

  bit [19:0] blk_start[TABLE_DEPTH];
  bit [19:0] blk_size[TABLE_DEPTH];
  bit        blk_free[TABLE_DEPTH];
  int        blk_count;
  bit [19:0] exp_addr[$];
  bit [1:0]  exp_status[$];
  int        errors;

  function void reinit(bit [19:0] heap);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      blk_start[k] = '0;
      blk_size[k]  = '0;
      blk_free[k]  = 1'b0;
    end
    blk_start[0] = HDR;
    blk_size[0]  = heap;
    blk_free[0]  = 1'b1;
    blk_count    = 1;
  endfunction

  function void drop_entry(int idx);
    for (int k = idx; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_free[k]  = blk_free[k+1];
    end
    blk_count--;
    blk_start[blk_count] = '0;
    blk_size[blk_count]  = '0;
    blk_free[blk_count]  = 1'b0;
  endfunction

  // first fit, split when the remainder holds a header and the table has room
  function void predict_alloc(bit [19:0] req);
    int i;
    logic [63:0] need;
    i = 0;
    while (i < blk_count && !(blk_free[i] && blk_size[i] >= req)) i++;
    if (i >= blk_count) begin
      exp_addr.push_back('0);
      exp_status.push_back(ffha_pkg::ST_NOFIT);
      return;
    end
    need = 64'(req) + HDR;
    if (64'(blk_size[i]) >= need && blk_count < TABLE_DEPTH) begin
      for (int k = blk_count; k > i + 1; k--) begin
        blk_start[k] = blk_start[k-1];
        blk_size[k]  = blk_size[k-1];
        blk_free[k]  = blk_free[k-1];
      end
      blk_start[i+1] = 20'((64'(blk_start[i]) + need) & FIELD_MASK);
      blk_size[i+1]  = 20'((64'(blk_size[i]) - need) & FIELD_MASK);
      blk_free[i+1]  = 1'b1;
      blk_size[i]    = req;
      blk_count++;
    end
    blk_free[i] = 1'b0;
    exp_addr.push_back(blk_start[i]);
    exp_status.push_back(ffha_pkg::ST_OK);
  endfunction

  // mark free, then merge with the next and the previous neighbor
  function void predict_free(bit [19:0] addr);
    int i;
    i = 0;
    while (i < blk_count && blk_start[i] != addr) i++;
    exp_addr.push_back('0);
    if (i >= blk_count) begin
      exp_status.push_back(ffha_pkg::ST_NOTFND);
      return;
    end
    blk_free[i] = 1'b1;
    if (i + 1 < blk_count && blk_free[i+1]) begin
      blk_size[i] = 20'((64'(blk_size[i]) + HDR + blk_size[i+1]) & FIELD_MASK);
      drop_entry(i + 1);
    end
    if (i > 0 && blk_free[i-1]) begin
      blk_size[i-1] = 20'((64'(blk_size[i-1]) + HDR + blk_size[i]) & FIELD_MASK);
      drop_entry(i);
    end
    exp_status.push_back(ffha_pkg::ST_OK);
  endfunction

  function void note_request(bit action, bit [19:0] req, bit [19:0] addr);
    if (action == ffha_pkg::ACT_ALLOC) predict_alloc(req);
    else predict_free(addr);
  endfunction

  function void check_result(bit [19:0] addr, bit [1:0] status);
    if (exp_addr.size() == 0) begin
      $error("unexpected response address_out=%0h status=%0d", addr, status);
      errors++;
      return;
    end
    if (addr !== exp_addr[0]) begin
      $error("address_out expected %0h actual %0h", exp_addr[0], addr);
      errors++;
    end
    if (status !== exp_status[0]) begin
      $error("status expected %0d actual %0d", exp_status[0], status);
      errors++;
    end
    void'(exp_addr.pop_front());
    void'(exp_status.pop_front());
  endfunction

  function int pending();
    return exp_addr.size();
  endfunction

  // data offset of a random entry, mostly allocated ones
  function bit [19:0] pick_block();
    int idx;
    idx = $urandom_range(blk_count - 1);
    for (int k = 0; k < blk_count; k++)
      if (!blk_free[(idx + k) % blk_count] && $urandom_range(9) != 0)
        return blk_start[(idx + k) % blk_count];
    return blk_start[idx];
  endfunction
endclass

module tb_first_fit_heap_allocator_core;
  import ffha_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned SETTLE      = TABLE_DEPTH + 16;

  typedef struct packed {
    logic                  action;
    logic [FIELD_BITS-1:0] request_size;
    logic [FIELD_BITS-1:0] address;
  } alloc_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0]  address_out;
    logic [STATUS_BITS-1:0] status;
  } alloc_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [FIELD_BITS-1:0] cfg_wdata = '0;

  ffha_if #(.payload_t(alloc_req_t)) req_ch ();
  ffha_if #(.payload_t(alloc_rsp_t)) rsp_ch ();

  alloc_scoreboard heap_sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  first_fit_heap_allocator_core #(
    .MAX_BLOCKS  (TABLE_DEPTH),
    .HEADER_BYTES(32),
    .ADDR_BITS   (20)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (req_ch.valid),
    .in_ready       (req_ch.ready),
    .in_action      (req_ch.data.action),
    .in_request_size(req_ch.data.request_size),
    .in_address     (req_ch.data.address),
    .out_valid      (rsp_ch.valid),
    .out_ready      (rsp_ch.ready),
    .out_address_out(rsp_ch.data.address_out),
    .out_status     (rsp_ch.data.status)
  );

  // response side: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // pre-edge values are seen here, so a transfer is exactly valid and ready
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready)
      heap_sb.check_result(rsp_ch.data.address_out, rsp_ch.data.status);
  end

  // offer one request, with random idle cycles first, and hold it until the transfer
  task automatic send_req(logic action, logic [FIELD_BITS-1:0] req,
                          logic [FIELD_BITS-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{action: action, request_size: req, address: addr};
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    heap_sb.note_request(action, req, addr);
  endtask

  task automatic go_quiet();
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // heap_size write only once the core has drained and finished its last walk
  task automatic write_heap_size(logic [FIELD_BITS-1:0] heap);
    go_quiet();
    while (heap_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= heap;
    @(posedge clk);
    cfg_we <= 1'b0;
    heap_sb.reinit(heap);
  endtask

  // mostly small allocs and frees of live blocks, some large sizes and stray addresses
  task automatic random_req();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      if ($urandom_range(9) == 0)
        send_req(ACT_ALLOC, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
      else
        send_req(ACT_ALLOC, FIELD_BITS'($urandom_range(0, 400)), FIELD_BITS'($urandom));
    end else if (pick < 92) begin
      send_req(ACT_FREE, FIELD_BITS'($urandom), heap_sb.pick_block());
    end else begin
      send_req(ACT_FREE, FIELD_BITS'($urandom), FIELD_BITS'($urandom));
    end
  endtask

  initial begin
    logic [FIELD_BITS-1:0] heaps[5];
    logic [FIELD_BITS-1:0] held;
    heaps = '{20'd65536, 20'hFFFFF, 20'd3000, 20'd0, 20'd9000};
    heap_sb = new();
    heap_sb.reinit(20'd65536);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero request, oversize, unknown address, double free, exact reuse
    send_req(ACT_ALLOC, 20'd0, 20'd0);
    send_req(ACT_ALLOC, 20'hFFFFF, 20'hFFFFF);
    send_req(ACT_ALLOC, 20'd100, 20'd0);
    held = heap_sb.blk_start[1];
    send_req(ACT_ALLOC, 20'd100, 20'd0);
    send_req(ACT_ALLOC, 20'd68, 20'd0);
    send_req(ACT_FREE, 20'd0, 20'd12345);
    send_req(ACT_FREE, 20'hFFFFF, 20'hFFFFF);
    send_req(ACT_FREE, 20'd0, 20'd0);
    send_req(ACT_FREE, 20'd0, held);
    send_req(ACT_FREE, 20'd0, held);
    send_req(ACT_ALLOC, 20'd100, 20'd0);
    send_req(ACT_ALLOC, 20'd69, 20'd0);
    send_req(ACT_FREE, 20'd0, 20'd32);
    send_req(ACT_FREE, 20'd0, held);
    send_req(ACT_ALLOC, 20'd65536, 20'd0);

    // empty heap: only a zero request fits, with no room to split
    write_heap_size(20'd0);
    send_req(ACT_ALLOC, 20'd1, 20'd0);
    send_req(ACT_ALLOC, 20'd0, 20'd0);
    send_req(ACT_ALLOC, 20'd0, 20'd0);
    send_req(ACT_FREE, 20'd0, 20'd32);
    send_req(ACT_FREE, 20'd0, 20'd32);
    send_req(ACT_ALLOC, 20'd0, 20'd0);

    // random phases over several heap sizes and idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      write_heap_size(heaps[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // long response hold-off while requests keep coming, so the input backs up
      if (ph == 1) hold_left = 600;
      for (int n = 0; n < 165; n++) begin
        if (n % 40 == 39) begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        random_req();
      end
    end

    go_quiet();
    while (heap_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (heap_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
